// ===== hdl/arh_pkg.sv =====
// Shared types and constants for the auto-ranging histogram.
// No dependencies; imported by arh_div and auto_range_histogram_top.
package arh_pkg;

  localparam int SAMPLE_W    = 32;
  localparam int NUM_BINS    = 15;
  localparam int MAX_SAMPLES = 256;
  localparam int INDEX_W     = 6;
  localparam int COUNT_W     = 9;
  localparam int BIN_W       = $clog2(NUM_BINS);
  localparam int ADDR_W      = $clog2(MAX_SAMPLES);
  localparam int TOTAL_W     = $clog2(MAX_SAMPLES + 1);
  localparam int STEP_W      = $clog2(SAMPLE_W);

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                final_sample;
  } arh_sample_t;

  typedef struct packed {
    logic [INDEX_W-1:0] bin_index;
    logic [COUNT_W-1:0] bin_count;
    logic               last_bin;
  } arh_result_t;

  typedef enum logic [2:0] {
    S_LOAD,
    S_RANGE,
    S_WIDTH,
    S_READ,
    S_START,
    S_DIV,
    S_EMIT
  } arh_state_t;

endpackage

// ===== hdl/auto_range_histogram_top.sv =====
// Auto-ranging histogram: sample store, min/max tracking, binning sequencer.
// Depends on arh_pkg and arh_div.
//
// Loading: one request per cycle while no binning pass runs.
// Binning pass (after the request marked final_sample): the range/15 divide,
//   then per stored sample a read, a divider start and the divide in arh_div
//   (32 quotient bits plus done), then NUM_BINS result requests. A zero bin
//   width skips the per-sample walk.
// Reset (rst, synchronous) empties the run: count 0, min all ones, max 0,
//   no result pending. The sample memory is not cleared; only entries written
//   in the current run are ever read.
module auto_range_histogram_top
  import arh_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        sample_valid,
  output logic        sample_stall,
  input  arh_sample_t sample_req,
  output logic        result_valid,
  input  logic        result_stall,
  output arh_result_t result_req
);

  // ---------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------
  arh_state_t state, state_next;

  logic [SAMPLE_W-1:0] store_mem [MAX_SAMPLES];
  logic [SAMPLE_W-1:0] rdata;

  logic [TOTAL_W-1:0]  total;       // samples held this run
  logic [SAMPLE_W-1:0] running_min;
  logic [SAMPLE_W-1:0] running_max;
  logic [SAMPLE_W-1:0] width;       // bin width
  logic [TOTAL_W-1:0]  k;           // binning walk position
  logic [INDEX_W-1:0]  emit_idx;    // next bin to send
  logic [COUNT_W-1:0]  counts [NUM_BINS];

  // divider hookup
  logic                div_start;
  logic                div_done;
  logic [SAMPLE_W-1:0] div_dividend;
  logic [SAMPLE_W-1:0] div_divisor;
  logic [SAMPLE_W-1:0] div_quo;

  // sequencer outputs
  logic accept;
  logic store_en;
  logic emit_load;
  logic emit_last;
  logic bump_en;

  logic [BIN_W-1:0] bin_sel;

  assign accept    = sample_valid && !sample_stall;
  assign store_en  = accept && (total < TOTAL_W'(MAX_SAMPLES));
  assign emit_last = emit_idx == INDEX_W'(NUM_BINS - 1);

  // clamp the quotient to the last bin
  assign bin_sel = (div_quo >= SAMPLE_W'(NUM_BINS)) ? BIN_W'(NUM_BINS - 1)
                                                    : div_quo[BIN_W-1:0];

  // ---------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------
  always_comb begin
    state_next = state;
    unique case (state)
      S_LOAD: begin
        if (accept && sample_req.final_sample) state_next = S_RANGE;
      end
      S_RANGE: state_next = S_WIDTH;
      S_WIDTH: begin
        if (div_done) begin
          state_next = (div_quo == '0) ? S_EMIT : S_READ;
        end
      end
      S_READ:  state_next = S_START;
      S_START: state_next = S_DIV;
      S_DIV: begin
        if (div_done) begin
          state_next = (k + 1'b1 == total) ? S_EMIT : S_READ;
        end
      end
      S_EMIT: begin
        if (emit_load && emit_last) state_next = S_LOAD;
      end
      default: state_next = S_LOAD;
    endcase
  end

  // ---------------------------------------------------------------------
  // Sequencer outputs
  // ---------------------------------------------------------------------
  always_comb begin
    sample_stall = 1'b1;
    div_start    = 1'b0;
    div_dividend = running_max - running_min;
    div_divisor  = SAMPLE_W'(NUM_BINS);
    emit_load    = 1'b0;
    bump_en      = 1'b0;
    unique case (state)
      S_LOAD:  sample_stall = 1'b0;
      S_RANGE: div_start = 1'b1;
      S_WIDTH: ;
      S_READ:  ;
      S_START: begin
        div_start    = 1'b1;
        div_dividend = rdata - running_min;
        div_divisor  = width;
      end
      S_DIV:   bump_en = div_done;
      S_EMIT:  emit_load = !result_valid || !result_stall;
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_LOAD;
      total        <= '0;
      running_min  <= '1;
      running_max  <= '0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (store_en) begin
        total <= total + 1'b1;
        if (sample_req.sample < running_min) running_min <= sample_req.sample;
        if (sample_req.sample > running_max) running_max <= sample_req.sample;
      end
      // run ends once the last bin is handed to the output register
      if (emit_load && emit_last) begin
        total       <= '0;
        running_min <= '1;
        running_max <= '0;
      end
      if (emit_load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Sample memory: one write port at load, one registered read in the pass
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (store_en) store_mem[total[ADDR_W-1:0]] <= sample_req.sample;
    rdata <= store_mem[k[ADDR_W-1:0]];
  end

  // ---------------------------------------------------------------------
  // Binning datapath
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (state == S_RANGE) begin
      k        <= '0;
      emit_idx <= '0;
      for (int i = 0; i < NUM_BINS; i++) counts[i] <= '0;
    end
    if (state == S_WIDTH && div_done) begin
      width <= div_quo;
      // zero width: everything lands in bin 0
      if (div_quo == '0) begin
        if (32'(total) > 32'(COUNT_MAX)) counts[0] <= COUNT_MAX;
        else                             counts[0] <= COUNT_W'(total);
      end
    end
    if (bump_en) begin
      k <= k + 1'b1;
      if (counts[bin_sel] != COUNT_MAX) counts[bin_sel] <= counts[bin_sel] + 1'b1;
    end
    // bins leave from the bottom of a shift line
    if (emit_load) begin
      result_req.bin_index <= emit_idx;
      result_req.bin_count <= counts[0];
      result_req.last_bin  <= emit_last;
      emit_idx             <= emit_idx + 1'b1;
      for (int i = 0; i < NUM_BINS - 1; i++) counts[i] <= counts[i + 1];
      counts[NUM_BINS-1] <= '0;
    end
  end

  arh_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    total <= TOTAL_W'(MAX_SAMPLES))
    else $error("sample count beyond store depth");

  a_min_le_max: assert property (@(posedge clk) disable iff (rst)
    (total != '0) |-> (running_min <= running_max))
    else $error("running min above running max");

  a_done_phase: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_WIDTH || state == S_DIV))
    else $error("divider finished outside a wait state");

  a_last_tag: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result_req.last_bin == (result_req.bin_index == INDEX_W'(NUM_BINS - 1))))
    else $error("last_bin does not match final bin index");

  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ || state == S_START || state == S_DIV) |-> (k < total))
    else $error("binning walk past stored samples");

endmodule

// ===== hdl/arh_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on arh_pkg for SAMPLE_W and STEP_W.
module arh_div
  import arh_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [SAMPLE_W-1:0] dividend,
  input  logic [SAMPLE_W-1:0] divisor,
  output logic                done,
  output logic [SAMPLE_W-1:0] quotient
);

  logic                busy;
  logic [STEP_W-1:0]   step;
  logic [SAMPLE_W-1:0] rem;
  logic [SAMPLE_W-1:0] dsor;
  logic [SAMPLE_W-1:0] quo;
  logic [SAMPLE_W:0]   rem_shift;
  logic                fits;

  assign rem_shift = {rem, quo[SAMPLE_W-1]};
  assign fits      = rem_shift >= {1'b0, dsor};
  assign quotient  = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == STEP_W'(SAMPLE_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath: no reset needed
  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      quo  <= dividend;
      dsor <= divisor;
    end else if (busy) begin
      if (fits) begin
        rem <= SAMPLE_W'(rem_shift - {1'b0, dsor});
      end else begin
        rem <= rem_shift[SAMPLE_W-1:0];
      end
      quo <= {quo[SAMPLE_W-2:0], fits};
    end
  end

endmodule
